/* rtl/dsps_pkg.sv */
package dsps_pkg;

    localparam int NUM_MOTORS_DEF = 2;

    localparam int KIND_W     = 3;
    localparam int REV_W      = 16;
    localparam int PERIOD_W   = 16;
    localparam int STEPS_W    = 32;
    localparam int PHASE_W    = 4;
    localparam int COIL_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CMD_W      = 2;

    // Shared divider widths: 600000 needs 20 bits, divisors are at most 16 bits.
    localparam int DIVIDEND_W = 20;
    localparam int DIVISOR_W  = 16;
    localparam logic [DIVIDEND_W-1:0] PERIOD_BASE = 20'd600000;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    localparam logic [KIND_W-1:0] KIND_OFF  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WAVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HALF = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BIPO = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TYPE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REV1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REV2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REV3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REV4  = 3'd5;

    localparam logic [REV_W-1:0] REV1_RESET = 16'd2048;
    localparam logic [REV_W-1:0] REV2_RESET = 16'd2048;
    localparam logic [REV_W-1:0] REV3_RESET = 16'd4096;
    localparam logic [REV_W-1:0] REV4_RESET = 16'd200;

    localparam logic [COIL_W-1:0] TAB_WAVE [4] = '{4'd8, 4'd4, 4'd2, 4'd1};
    localparam logic [COIL_W-1:0] TAB_FULL [4] = '{4'd12, 4'd6, 4'd3, 4'd9};
    localparam logic [COIL_W-1:0] TAB_HALF [8] =
        '{4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9};
    localparam logic [COIL_W-1:0] TAB_BIPO [4] = '{4'd5, 4'd6, 4'd10, 4'd9};

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [PERIOD_W-1:0] tick_left;
        logic [PERIOD_W-1:0] period;
        logic [STEPS_W-1:0]  steps_left;
        logic                forward;
        logic [COIL_W-1:0]   coil;
        logic                enable;
    } chan_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rslt_t;

    function automatic logic kind_active(logic [KIND_W-1:0] kind);
        return (kind >= KIND_WAVE) && (kind <= KIND_BIPO);
    endfunction

    function automatic logic [COIL_W-1:0] coil_pattern(logic [KIND_W-1:0] kind,
                                                       logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] pat;
        case (kind)
            KIND_WAVE: pat = TAB_WAVE[ph[1:0]];
            KIND_FULL: pat = TAB_FULL[ph[1:0]];
            KIND_HALF: pat = TAB_HALF[ph[2:0]];
            default:   pat = TAB_BIPO[ph[1:0]];
        endcase
        return pat;
    endfunction

endpackage

/* rtl/dsps_divider.sv */
module dsps_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  dsps_pkg::div_req_t  req,
    output dsps_pkg::div_rslt_t rslt
);

    localparam int DW     = dsps_pkg::DIVIDEND_W;
    localparam int VW     = dsps_pkg::DIVISOR_W;
    localparam int CNT_W  = $clog2(DW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VW-1:0]    rem_reg;
    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    dsr_reg;

    logic [VW:0]      shifted;
    logic [VW+1:0]    diff;
    logic [VW-1:0]    rem_next;
    logic [DW-1:0]    quo_next;

    // One restoring step per cycle: shift in the next dividend bit, try to subtract.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        diff     = {1'b0, shifted} - {2'b00, dsr_reg};
        rem_next = diff[VW+1] ? shifted[VW-1:0] : diff[VW-1:0];
        quo_next = {quo_reg[DW-2:0], ~diff[VW+1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign rslt.done     = done_reg;
    assign rslt.quotient = quo_reg;

endmodule

/* rtl/dsps_chan_step.sv */
module dsps_chan_step
(
    input  dsps_pkg::chan_t                   chan,
    input  logic [dsps_pkg::KIND_W-1:0]       kind,
    output dsps_pkg::chan_t                   chan_next
);

    logic [dsps_pkg::PHASE_W-1:0] top;
    logic [dsps_pkg::PHASE_W-1:0] ph;
    logic [dsps_pkg::STEPS_W-1:0] steps_dec;

    always_comb
    begin
        top = (kind == dsps_pkg::KIND_HALF) ? 4'd7 : 4'd3;
        if (chan.forward)
        begin
            ph = chan.phase + 4'd1;
            if (ph > top)
            begin
                ph = 4'd0;
            end
        end
        else
        begin
            ph = (chan.phase == 4'd0) ? top : chan.phase - 4'd1;
            if (ph > top)
            begin
                ph = top;
            end
        end
        steps_dec = chan.steps_left - 32'd1;

        chan_next = chan;
        if (dsps_pkg::kind_active(kind) && (chan.steps_left != '0))
        begin
            if (chan.tick_left <= 16'd1)
            begin
                chan_next.tick_left  = chan.period;
                chan_next.phase      = ph;
                chan_next.coil       = dsps_pkg::coil_pattern(kind, ph);
                chan_next.steps_left = steps_dec;
                // The last step of a run releases the windings.
                if (steps_dec == '0)
                begin
                    chan_next.coil   = '0;
                    chan_next.enable = 1'b0;
                end
            end
            else
            begin
                chan_next.tick_left = chan.tick_left - 16'd1;
            end
        end
    end

endmodule

/* rtl/dual_stepper_phase_sequencer.sv */
// Tick transaction: S_DECODE, then S_TICK, where the channels are stepped one per cycle,
// then S_RESULT. Run transaction: two passes through the shared divider of 20 steps.
// Stop, idle and an ignored run go from S_DECODE straight to S_RESULT. A new command is
// taken only in S_IDLE, once the previous result has been loaded.
// The result sits in an output register; a result still waiting when the next is due holds it.
// Reset clears all channel state; motor kinds reset to 1 and 0, steps per turn to defaults.
module dual_stepper_phase_sequencer
#(
    parameter int NUM_MOTORS = dsps_pkg::NUM_MOTORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: motor[0], step_count[32:1], speed[40:33], clockwise[41], zero fill
    input  logic [47:0] s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: coils0[3:0], coils1[7:4], enable0[8], enable1[9],
    // left0[41:10], left1[73:42], zero fill
    output logic [79:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dsps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsps_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int MIDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic [MIDX_W-1:0] IDX_LAST = MIDX_W'(NUM_MOTORS - 1);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DECODE,
        S_DIV1,
        S_DIV2GO,
        S_DIV2,
        S_TICK,
        S_RESULT
    } state_t;

    state_t                                state_reg;
    logic [MIDX_W-1:0]                     idx_reg;
    logic [dsps_pkg::CMD_W-1:0]            cmd_reg;
    logic                                  motor_reg;
    logic [dsps_pkg::STEPS_W-1:0]          count_reg;
    logic [7:0]                            speed_reg;
    logic                                  cw_reg;
    logic [dsps_pkg::DIVIDEND_W-1:0]       q1_reg;
    logic                                  m_tvalid_reg;
    logic [79:0]                           m_tdata_reg;

    dsps_pkg::chan_t                       chan_reg [NUM_MOTORS];
    logic [dsps_pkg::KIND_W-1:0]           type_reg [NUM_MOTORS];
    logic [dsps_pkg::REV_W-1:0]            rev_reg  [4];

    logic [MIDX_W-1:0]                     m_idx;
    logic                                  m_present;
    logic [MIDX_W-1:0]                     sel_idx;
    dsps_pkg::chan_t                       cur_chan;
    logic [dsps_pkg::KIND_W-1:0]           cur_kind;
    logic [dsps_pkg::KIND_W-1:0]           kind_m1;
    logic [dsps_pkg::REV_W-1:0]            rev_eff;
    logic [7:0]                            spd_eff;
    logic                                  run_ok;
    logic [dsps_pkg::PERIOD_W-1:0]         period_q;
    dsps_pkg::chan_t                       tick_chan;
    dsps_pkg::chan_t                       run_chan;
    dsps_pkg::chan_t                       stop_chan;
    dsps_pkg::div_req_t                    div_req;
    dsps_pkg::div_rslt_t                   div_rslt;

    logic [3:0]                            coils1;
    logic                                  enable1;
    logic [31:0]                           left1;
    logic [79:0]                           out_word;

    assign m_idx     = MIDX_W'(motor_reg);
    assign m_present = (int'(motor_reg) < NUM_MOTORS);
    assign sel_idx   = (state_reg == S_TICK) ? idx_reg : m_idx;
    assign cur_chan  = chan_reg[sel_idx];
    assign cur_kind  = type_reg[sel_idx];

    always_comb
    begin
        kind_m1  = cur_kind - 3'd1;
        rev_eff  = (rev_reg[kind_m1[1:0]] == '0) ? 16'd1 : rev_reg[kind_m1[1:0]];
        spd_eff  = (speed_reg == 8'd0) ? 8'd1 : speed_reg;
        run_ok   = m_present && dsps_pkg::kind_active(cur_kind);

        if (|div_rslt.quotient[dsps_pkg::DIVIDEND_W-1:dsps_pkg::PERIOD_W])
        begin
            period_q = 16'hFFFF;
        end
        else if (div_rslt.quotient == '0)
        begin
            period_q = 16'd1;
        end
        else
        begin
            period_q = div_rslt.quotient[dsps_pkg::PERIOD_W-1:0];
        end

        run_chan            = cur_chan;
        run_chan.period     = period_q;
        run_chan.tick_left  = period_q;
        run_chan.forward    = cw_reg;
        run_chan.enable     = 1'b1;
        run_chan.steps_left = count_reg;
        if (cw_reg)
        begin
            run_chan.phase = 4'd15;
        end
        else
        begin
            run_chan.phase = (cur_kind == dsps_pkg::KIND_HALF) ? 4'd8 : 4'd4;
        end

        stop_chan            = cur_chan;
        stop_chan.steps_left = '0;

        div_req.start    = ((state_reg == S_DECODE) && (cmd_reg == dsps_pkg::CMD_RUN)
                            && run_ok) || (state_reg == S_DIV2GO);
        div_req.dividend = (state_reg == S_DIV2GO) ? q1_reg : dsps_pkg::PERIOD_BASE;
        div_req.divisor  = (state_reg == S_DIV2GO) ? {8'd0, spd_eff} : rev_eff;
    end

    dsps_chan_step u_chan_step
    (
        .chan      (cur_chan),
        .kind      (cur_kind),
        .chan_next (tick_chan)
    );

    dsps_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rslt  (div_rslt)
    );

    generate
        if (NUM_MOTORS > 1)
        begin : g_ch1
            assign coils1  = chan_reg[1].coil;
            assign enable1 = chan_reg[1].enable;
            assign left1   = chan_reg[1].steps_left;
        end
        else
        begin : g_no_ch1
            assign coils1  = '0;
            assign enable1 = 1'b0;
            assign left1   = '0;
        end
    endgenerate

    assign out_word = {6'd0, left1, chan_reg[0].steps_left, enable1, chan_reg[0].enable,
                       coils1, chan_reg[0].coil};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            cmd_reg      <= dsps_pkg::CMD_TICK;
            motor_reg    <= 1'b0;
            count_reg    <= '0;
            speed_reg    <= '0;
            cw_reg       <= 1'b0;
            q1_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                chan_reg[i] <= '0;
                type_reg[i] <= (i == 0) ? dsps_pkg::KIND_WAVE : dsps_pkg::KIND_OFF;
            end
            rev_reg[0] <= dsps_pkg::REV1_RESET;
            rev_reg[1] <= dsps_pkg::REV2_RESET;
            rev_reg[2] <= dsps_pkg::REV3_RESET;
            rev_reg[3] <= dsps_pkg::REV4_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    dsps_pkg::CFG_TYPE0,
                    dsps_pkg::CFG_TYPE1:
                    begin
                        for (int i = 0; i < NUM_MOTORS; i++)
                        begin
                            if ((i < 2) && (cfg_index == dsps_pkg::CFG_IDX_W'(i)))
                            begin
                                type_reg[i] <= cfg_data[dsps_pkg::KIND_W-1:0];
                            end
                        end
                    end
                    dsps_pkg::CFG_REV1: rev_reg[0] <= cfg_data;
                    dsps_pkg::CFG_REV2: rev_reg[1] <= cfg_data;
                    dsps_pkg::CFG_REV3: rev_reg[2] <= cfg_data;
                    dsps_pkg::CFG_REV4: rev_reg[3] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // While a new result is being loaded, that state sets the valid flag itself.
            if (m_tvalid_reg && m_tready && (state_reg != S_RESULT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg   <= s_tuser;
                        motor_reg <= s_tdata[0];
                        count_reg <= s_tdata[32:1];
                        speed_reg <= s_tdata[40:33];
                        cw_reg    <= s_tdata[41];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    idx_reg <= '0;
                    case (cmd_reg)
                        dsps_pkg::CMD_TICK: state_reg <= S_TICK;
                        dsps_pkg::CMD_RUN:  state_reg <= run_ok ? S_DIV1 : S_RESULT;
                        dsps_pkg::CMD_STOP:
                        begin
                            if (m_present)
                            begin
                                chan_reg[m_idx] <= stop_chan;
                            end
                            state_reg <= S_RESULT;
                        end
                        default: state_reg <= S_RESULT;
                    endcase
                end
                S_DIV1:
                begin
                    if (div_rslt.done)
                    begin
                        q1_reg    <= div_rslt.quotient;
                        state_reg <= S_DIV2GO;
                    end
                end
                S_DIV2GO:
                begin
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    if (div_rslt.done)
                    begin
                        chan_reg[m_idx] <= run_chan;
                        state_reg       <= S_RESULT;
                    end
                end
                S_TICK:
                begin
                    chan_reg[idx_reg] <= tick_chan;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_RESULT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= out_word;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule

/* verif/dsps_checker.sv */
module dsps_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // tdata: motor[0], step_count[32:1], speed[40:33], clockwise[41], zero fill
    input  logic [47:0]                     s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: coils0[3:0], coils1[7:4], enable0[8], enable1[9],
    // left0[41:10], left1[73:42], zero fill
    input  logic [79:0]                     m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dsps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsps_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              steps_fired,
    output int                              runs_loaded
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]  fill;
        logic        cw;
        logic [7:0]  speed;
        logic [31:0] count;
        logic        motor;
    } cmd_word_t;

    typedef struct packed {
        logic [5:0]  fill;
        logic [31:0] left1;
        logic [31:0] left0;
        logic        enable1;
        logic        enable0;
        logic [3:0]  coils1;
        logic [3:0]  coils0;
    } drive_word_t;

    // Coil patterns, entry i in bits [4*i +: 4].
    localparam logic [15:0] WAVE_SEQ = {4'd1, 4'd2, 4'd4, 4'd8};
    localparam logic [15:0] FULL_SEQ = {4'd9, 4'd3, 4'd6, 4'd12};
    localparam logic [31:0] HALF_SEQ = {4'd9, 4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8};
    localparam logic [15:0] BIPO_SEQ = {4'd9, 4'd10, 4'd6, 4'd5};

    logic [2:0]  motor_kind [2];
    logic [15:0] turn_steps [4];
    logic [3:0]  ch_phase   [2];
    logic [15:0] ch_ticks   [2];
    logic [15:0] ch_period  [2];
    logic [31:0] ch_left    [2];
    logic        ch_fwd     [2];
    logic [3:0]  ch_coil    [2];
    logic        ch_en      [2];

    drive_word_t drive_state_q [$];
    drive_word_t want;
    drive_word_t got;

    function automatic logic kind_on(input logic [2:0] kind);
        return kind >= dsps_pkg::KIND_WAVE && kind <= dsps_pkg::KIND_BIPO;
    endfunction

    function automatic logic [3:0] coil_for(input logic [2:0] kind, input logic [3:0] ph);
        case (kind)
            dsps_pkg::KIND_WAVE: return WAVE_SEQ[int'(ph[1:0]) * 4 +: 4];
            dsps_pkg::KIND_FULL: return FULL_SEQ[int'(ph[1:0]) * 4 +: 4];
            dsps_pkg::KIND_HALF: return HALF_SEQ[int'(ph[2:0]) * 4 +: 4];
            default:             return BIPO_SEQ[int'(ph[1:0]) * 4 +: 4];
        endcase
    endfunction

    task automatic take_step(input int m);
        logic [3:0] last;
        logic [3:0] p;
        last = (motor_kind[m] == dsps_pkg::KIND_HALF) ? 4'd7 : 4'd3;
        p = ch_phase[m];
        // Phase past the table (kind change): forward to 0, backward to last.
        if (ch_fwd[m]) begin
            p = p + 4'd1;
            if (p > last) p = 4'd0;
        end else begin
            p = (p == 4'd0) ? last : p - 4'd1;
            if (p > last) p = last;
        end
        ch_phase[m] = p;
        ch_coil[m] = coil_for(motor_kind[m], p);
        ch_left[m] = ch_left[m] - 32'd1;
        if (ch_left[m] == 32'd0) begin
            ch_coil[m] = 4'd0;
            ch_en[m] = 1'b0;
        end
        steps_fired++;
    endtask

    task automatic load_run(input int m, input cmd_word_t w);
        logic [31:0] rev;
        logic [31:0] div;
        logic [31:0] q;
        if (!kind_on(motor_kind[m])) return;
        rev = {16'd0, turn_steps[motor_kind[m] - 3'd1]};
        if (rev == 32'd0) rev = 32'd1;
        div = (w.speed == 8'd0) ? 32'd1 : {24'd0, w.speed};
        q = 32'd600000 / rev / div;
        if (q > 32'd65535) q = 32'd65535;
        if (q == 32'd0) q = 32'd1;
        ch_period[m] = q[15:0];
        ch_ticks[m] = q[15:0];
        ch_fwd[m] = w.cw;
        if (w.cw) ch_phase[m] = 4'd15;
        else ch_phase[m] = (motor_kind[m] == dsps_pkg::KIND_HALF) ? 4'd8 : 4'd4;
        ch_en[m] = 1'b1;
        ch_left[m] = w.count;
        runs_loaded++;
    endtask

    task automatic apply_motor_cmd(input logic [1:0] cmd, input cmd_word_t w);
        int k;
        case (cmd)
            dsps_pkg::CMD_TICK:
                for (k = 0; k < 2; k++) begin
                    if (kind_on(motor_kind[k]) && ch_left[k] != 32'd0) begin
                        if (ch_ticks[k] <= 16'd1) begin
                            ch_ticks[k] = ch_period[k];
                            take_step(k);
                        end else begin
                            ch_ticks[k] = ch_ticks[k] - 16'd1;
                        end
                    end
                end
            dsps_pkg::CMD_RUN:  load_run(int'(w.motor), w);
            dsps_pkg::CMD_STOP: ch_left[w.motor] = 32'd0;
            default:  ;
        endcase
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            dsps_pkg::CFG_TYPE0: motor_kind[0] = val[2:0];
            dsps_pkg::CFG_TYPE1: motor_kind[1] = val[2:0];
            dsps_pkg::CFG_REV1:  turn_steps[0] = val;
            dsps_pkg::CFG_REV2:  turn_steps[1] = val;
            dsps_pkg::CFG_REV3:  turn_steps[2] = val;
            dsps_pkg::CFG_REV4:  turn_steps[3] = val;
            default:   ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            motor_kind[0] = dsps_pkg::KIND_WAVE;
            motor_kind[1] = dsps_pkg::KIND_OFF;
            turn_steps[0] = 16'd2048;
            turn_steps[1] = 16'd2048;
            turn_steps[2] = 16'd4096;
            turn_steps[3] = 16'd200;
            for (int k = 0; k < 2; k++) begin
                ch_phase[k] = '0;
                ch_ticks[k] = '0;
                ch_period[k] = '0;
                ch_left[k] = '0;
                ch_fwd[k] = 1'b0;
                ch_coil[k] = '0;
                ch_en[k] = 1'b0;
            end
            drive_state_q.delete();
            mismatches = 0;
            outstanding = 0;
            steps_fired = 0;
            runs_loaded = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (m_tvalid && m_tready) begin
                if (drive_state_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result 0x%0h arrived with no command pending",
                             $time, m_tdata);
                end else begin
                    want = drive_state_q.pop_front();
                    got = m_tdata;
                    check_field("coils0", 32'(want.coils0), 32'(got.coils0));
                    check_field("coils1", 32'(want.coils1), 32'(got.coils1));
                    check_field("enable0", 32'(want.enable0), 32'(got.enable0));
                    check_field("enable1", 32'(want.enable1), 32'(got.enable1));
                    check_field("left0", want.left0, got.left0);
                    check_field("left1", want.left1, got.left1);
                    check_field("zero fill", 32'(want.fill), 32'(got.fill));
                end
            end
            if (s_tvalid && s_tready) begin
                apply_motor_cmd(s_tuser, s_tdata);
                want.fill = '0;
                want.coils0 = ch_coil[0];
                want.coils1 = ch_coil[1];
                want.enable0 = ch_en[0];
                want.enable1 = ch_en[1];
                want.left0 = ch_left[0];
                want.left1 = ch_left[1];
                drive_state_q.push_back(want);
            end
            outstanding = drive_state_q.size();
        end
    end

endmodule

/* verif/tb_dual_stepper_phase_sequencer.sv */
module tb_dual_stepper_phase_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 110;

    localparam logic [dsps_pkg::CMD_W-1:0]     CMD_IDLE   = 2'd3;
    localparam logic [dsps_pkg::CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [dsps_pkg::CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [47:0]                     s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [79:0]                     m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [dsps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dsps_pkg::CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int steps_fired;
    int runs_loaded;
    int idle_odds = 4;
    int stall_left = 0;
    int quiet_cycles = 0;
    int cmds_sent = 0;
    int writes_done = 0;

    dual_stepper_phase_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dsps_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .steps_fired (steps_fired),
        .runs_loaded (runs_loaded)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result back-pressure comes in bursts of random length.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cmd(input logic [dsps_pkg::CMD_W-1:0] cmd, input logic motor,
                            input logic [31:0] count, input logic [7:0] speed,
                            input logic cw);
        cfg_valid <= 1'b0;
        if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, cw, speed, count, motor};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        cmds_sent++;
    endtask

    task automatic write_reg(input logic [dsps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        writes_done++;
    endtask

    // Lets every pending result come back and the block settle before a register write.
    task automatic drain();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic ticks(input int n);
        repeat (n) send_cmd(dsps_pkg::CMD_TICK, 1'($urandom), $urandom, 8'($urandom),
                            1'($urandom));
    endtask

    task automatic random_config();
        logic [12:0] upper;
        logic [15:0] val;
        int k;
        for (k = 0; k < 2; k++)
        begin
            upper = 13'($urandom);
            if ($urandom_range(0, 9) < 8)
                val = {upper, 3'($urandom_range(1, 4))};
            else
                val = {upper, 3'($urandom_range(0, 7))};
            write_reg(k == 0 ? dsps_pkg::CFG_TYPE0 : dsps_pkg::CFG_TYPE1, val);
        end
        for (k = 0; k < 4; k++)
        begin
            case ($urandom_range(0, 9))
                0:       val = 16'($urandom);
                1:       val = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
                default: val = 16'($urandom_range(3000, 65535));
            endcase
            write_reg(dsps_pkg::CFG_REV1 + 3'(k), val);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) == 0 ? CFG_SPARE6 : CFG_SPARE7, 16'($urandom));
    endtask

    task automatic send_random_cmd();
        int pick;
        logic [dsps_pkg::CMD_W-1:0] cmd;
        logic [31:0] count;
        logic [7:0] speed;
        pick = $urandom_range(0, 99);
        count = $urandom;
        speed = 8'($urandom);
        if (pick < 72)
        begin
            cmd = dsps_pkg::CMD_TICK;
        end
        else if (pick < 86)
        begin
            // Mostly short runs that finish, now and then one that needs a stop.
            cmd = dsps_pkg::CMD_RUN;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                count = $urandom_range(0, 30);
            else if (pick < 9)
                count = $urandom_range(31, 300);
            if ($urandom_range(0, 3) != 0)
                speed = 8'($urandom_range(120, 255));
        end
        else if (pick < 94)
        begin
            cmd = dsps_pkg::CMD_STOP;
        end
        else
        begin
            cmd = CMD_IDLE;
        end
        send_cmd(cmd, 1'($urandom), count, speed, 1'($urandom));
    endtask

    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: motor 0 wave drive, motor 1 off.
        send_cmd(CMD_IDLE, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_cmd(dsps_pkg::CMD_RUN, 1'b1, 32'd5, 8'd10, 1'b1);
        send_cmd(dsps_pkg::CMD_RUN, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_cmd(dsps_pkg::CMD_TICK, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_cmd(dsps_pkg::CMD_TICK, 1'b0, 32'd0, 8'd0, 1'b0);
        send_cmd(dsps_pkg::CMD_STOP, 1'b0, 32'd0, 8'd0, 1'b0);
        send_cmd(dsps_pkg::CMD_RUN, 1'b0, 32'd0, 8'd0, 1'b0);
        send_cmd(dsps_pkg::CMD_TICK, 1'b0, 32'd0, 8'd0, 1'b0);

        // Zero steps per turn saturates the period; a tiny quotient clamps to one.
        drain();
        write_reg(dsps_pkg::CFG_TYPE0, 16'hFFFB);
        write_reg(dsps_pkg::CFG_TYPE1, 16'h0004);
        write_reg(dsps_pkg::CFG_REV3, 16'h0000);
        write_reg(dsps_pkg::CFG_REV4, 16'hFFFF);
        send_cmd(dsps_pkg::CMD_RUN, 1'b0, 32'd2, 8'd0, 1'b0);
        send_cmd(dsps_pkg::CMD_STOP, 1'b0, 32'd0, 8'd0, 1'b0);
        send_cmd(dsps_pkg::CMD_RUN, 1'b1, 32'd3, 8'd255, 1'b0);
        ticks(3);

        // Unused kind codes and register indexes.
        drain();
        write_reg(dsps_pkg::CFG_TYPE0, 16'h0007);
        write_reg(dsps_pkg::CFG_TYPE1, 16'h0005);
        write_reg(dsps_pkg::CFG_REV1, 16'h0001);
        write_reg(dsps_pkg::CFG_REV2, 16'hFFFF);
        write_reg(CFG_SPARE6, 16'hFFFF);
        write_reg(CFG_SPARE7, 16'h0000);
        send_cmd(dsps_pkg::CMD_RUN, 1'b0, 32'd9, 8'd1, 1'b1);
        send_cmd(dsps_pkg::CMD_TICK, 1'b0, 32'd0, 8'd0, 1'b0);

        // Half-step both ways, then switch to four-phase kinds mid-run so the
        // phases sit past the end of the shorter table.
        drain();
        write_reg(dsps_pkg::CFG_TYPE0, 16'h0003);
        write_reg(dsps_pkg::CFG_TYPE1, 16'h0003);
        write_reg(dsps_pkg::CFG_REV3, 16'hFFFF);
        send_cmd(dsps_pkg::CMD_RUN, 1'b0, 32'd40, 8'd255, 1'b1);
        send_cmd(dsps_pkg::CMD_RUN, 1'b1, 32'd40, 8'd4, 1'b0);
        ticks(5);
        drain();
        write_reg(dsps_pkg::CFG_TYPE0, 16'h0001);
        write_reg(dsps_pkg::CFG_TYPE1, 16'h0002);
        ticks(2);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            random_config();
            if (p == RANDOM_PHASES - 1 || $urandom_range(0, 3) == 0)
                idle_odds = 0;
            else
                idle_odds = $urandom_range(2, 7);
            repeat (ITEMS_PER_PHASE) send_random_cmd();
        end

        drain();
        $display("Sent %0d command transactions and %0d register writes.",
                 cmds_sent, writes_done);
        $display("Runs loaded: %0d, coil steps taken: %0d.", runs_loaded, steps_fired);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dsps_pkg.sv
rtl/dsps_divider.sv
rtl/dsps_chan_step.sv
rtl/dual_stepper_phase_sequencer.sv
verif/dsps_checker.sv
verif/tb_dual_stepper_phase_sequencer.sv
